@@ rtl/sha_pkg.sv @@
// Package for the SHA-256 stream hasher: item types, codes, constants
// and the rotate function. No dependencies.
package sha_pkg;

   localparam int BlockBytes = 64;
   localparam int Rounds = 64;
   localparam int DigestWords = 8;

   localparam logic [1:0] ACT_ABSORB = 2'd0;
   localparam logic [1:0] ACT_ABSORB_FINISH = 2'd1;
   localparam logic [1:0] ACT_FINISH = 2'd2;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef logic [31:0] word_type;

   localparam word_type INIT_H [DigestWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam word_type ROUND_K [Rounds] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type ror(input word_type x, input int n);
      ror = (x >> n) | (x << (32 - n));
   endfunction

endpackage

@@ rtl/sha_round.sv @@
// One SHA-256 round unit, shared over all 64 rounds, with its own message
// schedule window of sixteen words. Depends on sha_pkg.
module sha_round
   import sha_pkg::*;
(
   input  logic     clock,
   input  logic     load,
   input  word_type load_word,
   input  logic     step,
   input  logic     init,
   input  word_type init_v [8],
   input  logic [5:0] round,
   output word_type v_out [8]
);

   word_type w_ff [16];
   word_type w_in [16];
   word_type v_ff [8];
   word_type v_in [8];
   word_type lo, hi, wnew, wcur, t1, t2, big0, big1, ch, maj;

   always_comb begin
      lo = ror(w_ff[1], 7) ^ ror(w_ff[1], 18) ^ (w_ff[1] >> 3);
      hi = ror(w_ff[14], 17) ^ ror(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + lo + w_ff[9] + hi;
      wcur = w_ff[0];
      big1 = ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25);
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1 = v_ff[7] + big1 + ch + ROUND_K[round] + wcur;
      big0 = ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22);
      maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2 = big0 + maj;
      w_in = w_ff;
      v_in = v_ff;
      if (load || step) begin
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i + 1];
         w_in[15] = load ? load_word : wnew;
      end
      if (init) begin
         v_in = init_v;
      end else if (step) begin
         v_in[7] = v_ff[6]; v_in[6] = v_ff[5]; v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2]; v_in[2] = v_ff[1]; v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
   end

   assign v_out = v_ff;

endmodule

@@ rtl/sha256_stream_hasher.sv @@
// SHA-256 stream hasher: top level with byte gathering, padding sequencer
// and digest output. Depends on sha_pkg and sha_round.
//
// Usage: the req channel carries one item per message byte (action 0),
// a last byte with finish (action 1) or a bare finish (action 2); action 3
// is dropped. The rsp channel returns eight digest words per finish, most
// significant first, word_index 0..7, last_word set on the eighth.
// Bytes are packed into words and shifted straight into the schedule window
// of the shared round unit, so no block store is kept.
// A plain byte that does not fill a block leaves req_ready high. A byte
// that completes a 64-byte block starts the compression: 64 rounds in one
// shared round unit, then an add into the hash words; req_ready returns
// once the add is done.
// A finish feeds padding and length bytes one per cycle and runs one or two
// compressions before the first digest word appears. The words are then
// presented one per accepted rsp item; a stalled receiver holds the block
// until all eight are taken.
// After the eighth word the hash words return to their initial values.
// Reset (synchronous, active high) restores initial hash values, fill and
// byte count.
module sha256_stream_hasher
   import sha_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {S_IDLE, S_ROUND, S_ADD, S_PAD, S_OUT} state_type;

   state_type   state_ff;
   logic [5:0]  fill_ff;
   logic [63:0] count_ff;
   logic        fin_ff;
   logic [5:0]  cnt_ff;
   logic [3:0]  pad_ff;
   logic [63:0] bits_ff;
   word_type    h_ff [8];
   logic [23:0] part_ff;

   word_type v_out [8];
   logic     rnd_load, rnd_step, rnd_init;
   word_type load_word;
   logic [7:0] pad_byte;
   logic       put;
   logic [7:0] put_byte;

   assign load_word = {part_ff, put_byte};
   assign rnd_load = put && (fill_ff[1:0] == 2'd3);
   assign rnd_step = (state_ff == S_ROUND);
   assign rnd_init = (state_ff == S_IDLE) || (state_ff == S_PAD);

   sha_round u_round (
      .clock(clock), .load(rnd_load), .load_word(load_word), .step(rnd_step),
      .init(rnd_init), .init_v(h_ff), .round(cnt_ff), .v_out(v_out));

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data.digest_word = h_ff[cnt_ff[2:0]];
   assign rsp_data.word_index = cnt_ff[2:0];
   assign rsp_data.last_word = (cnt_ff[2:0] == 3'd7);

   always_comb begin
      if (pad_ff == 4'd0) pad_byte = PAD_BYTE;
      else if (pad_ff == 4'd1) pad_byte = 8'd0;
      else pad_byte = bits_ff[63 - 8 * (pad_ff - 4'd2) -: 8];
      put = 1'b0;
      put_byte = req_data.data_byte;
      if (state_ff == S_IDLE && req_valid &&
          (req_data.action == ACT_ABSORB || req_data.action == ACT_ABSORB_FINISH)) put = 1'b1;
      if (state_ff == S_PAD) begin
         put = 1'b1;
         put_byte = pad_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (put) part_ff <= {part_ff[15:0], put_byte};
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff <= '0;
         count_ff <= '0;
         fin_ff <= 1'b0;
         cnt_ff <= '0;
         pad_ff <= '0;
         h_ff <= INIT_H;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               unique case (req_data.action)
                  ACT_ABSORB, ACT_ABSORB_FINISH: begin
                     count_ff <= count_ff + 64'd1;
                     bits_ff <= {count_ff[60:0] + 61'd1, 3'd0};
                     fill_ff <= fill_ff + 6'd1;
                     fin_ff <= (req_data.action == ACT_ABSORB_FINISH);
                     pad_ff <= '0;
                     cnt_ff <= '0;
                     if (fill_ff == 6'd63) state_ff <= S_ROUND;
                     else if (req_data.action == ACT_ABSORB_FINISH) state_ff <= S_PAD;
                  end
                  ACT_FINISH: begin
                     bits_ff <= {count_ff[60:0], 3'd0};
                     fin_ff <= 1'b1;
                     pad_ff <= '0;
                     state_ff <= S_PAD;
                  end
                  default: ;
               endcase
            end
            S_PAD: begin
               fill_ff <= fill_ff + 6'd1;
               if (fill_ff == LEN_POS - 6'd1) pad_ff <= 4'd2;
               else if (pad_ff < 4'd2) pad_ff <= 4'd1;
               else pad_ff <= pad_ff + 4'd1;
               if (fill_ff == 6'd63) begin
                  cnt_ff <= '0;
                  state_ff <= S_ROUND;
               end
            end
            S_ROUND: begin
               cnt_ff <= cnt_ff + 6'd1;
               if (cnt_ff == 6'(Rounds - 1)) state_ff <= S_ADD;
            end
            S_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_out[i];
               cnt_ff <= '0;
               if (!fin_ff) state_ff <= S_IDLE;
               else if (pad_ff == 4'd10) state_ff <= S_OUT;
               else state_ff <= S_PAD;
            end
            S_OUT: if (rsp_ready) begin
               if (cnt_ff[2:0] == 3'd7) begin
                  h_ff <= INIT_H;
                  fill_ff <= '0;
                  count_ff <= '0;
                  fin_ff <= 1'b0;
                  cnt_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  cnt_ff <= cnt_ff + 6'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ rtl/sha_checker.sv @@
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// Depends on sha_pkg and sha256_stream_hasher.
module sha_checker
   import sha_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("req ready while digest pending");
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_word == (rsp_data.word_index == 3'd7)))
      else $error("last_word mismatch");
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_data.last_word |=>
      rsp_valid && rsp_data.word_index == $past(rsp_data.word_index) + 3'd1)
      else $error("word index out of order");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp dropped under stall");
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req item changed while waiting");

endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (.*);
